>>> rtl/core/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg
// Shared types and constants of the wheel momentum scroll engine.
// ----------------------------------------------------------------------------
package wms_pkg;

    // action codes carried in s_axis_tuser
    localparam logic [2:0] ACT_WHEEL   = 3'd0;
    localparam logic [2:0] ACT_TICK    = 3'd1;
    localparam logic [2:0] ACT_PRESS   = 3'd2;
    localparam logic [2:0] ACT_RELEASE = 3'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DECEL    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOTCH_SIZE   = 2'd3;

    // register reset values
    localparam logic [15:0] MAX_VELOCITY_RST = 16'd100;
    localparam logic [7:0]  SCROLL_GAIN_RST  = 8'd32;
    localparam logic [15:0] MIN_DECEL_RST    = 16'd328;
    localparam logic [9:0]  NOTCH_SIZE_RST   = 10'd120;

    // max_velocity * 1000 fits in 26 bits
    localparam int unsigned MV_K_W   = 26;
    localparam logic [MV_K_W-1:0] MS_TO_US = 26'd1000;

    localparam logic [23:0] AMOUNT_MAX = 24'hFFFFFF;

    // divider step counts
    localparam int unsigned STEP_W = 6;
    localparam logic [STEP_W-1:0] DIV_STEPS = 6'd32;
    localparam logic [STEP_W-1:0] MOD_STEPS = 6'd16;

    typedef struct packed {
        logic item_load;
        logic wheel_begin;
        logic mod_start;
        logic elapsed_load;
        logic div_load;
        logic sample_take;
        logic vel_avg;
        logic notch_upd;
        logic tick_stop;
        logic mul_load;
        logic tick_upd;
        logic btn_press;
        logic btn_release;
        logic out_load;
    } wms_cmd_t;

    typedef struct packed {
        logic is_wheel;
        logic is_tick;
        logic is_press;
        logic is_release;
        logic mod_skip;
        logic rem_nz;
        logic ltv;
        logic running;
        logic stop_cond;
        logic sample_sat;
        logic div_busy;
        logic out_free;
    } wms_status_t;

endpackage

>>> rtl/core/wheel_momentum_scroll_engine_core.sv
// ----------------------------------------------------------------------------
// wheel_momentum_scroll_engine_core
// Inertial wheel-scroll engine: swallows wheel notches, estimates a velocity
// and emits decaying scroll amounts on timer ticks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per transfer: tuser holds the action code,
//   tdata the wheel delta and timestamp. Every event gives exactly one
//   result transfer on m_axis (flags in tuser, signed amount in tdata).
//   cfg writes a register (0 max_velocity, 1 scroll_gain, 2 min_decel,
//   3 notch_size); it is always ready and is meant for idle periods.
// Sequencing:
//   One event at a time. Button, tick and other events skip the divider.
//   A wheel notch first has its remainder checked by the shared restoring
//   divider; a consumed notch with a previous notch then divides again for
//   the velocity sample unless it saturates. A rejected notch leaves either
//   before the divider or after the remainder check.
// Reset:
//   Registers return to their defaults, velocity and all history clear.
// Stall:
//   A result waits in the output register; the next event is taken
//   meanwhile and its result is held back until the first one is taken.
// ----------------------------------------------------------------------------
module wheel_momentum_scroll_engine_core
    import wms_pkg::*;
#(
    parameter int unsigned VELOCITY_FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,   // delta[15:0], event_time[47:16]
    input  logic [2:0]           s_axis_tuser,   // action[2:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // scroll_amount[24:0], zero fill
    output logic [2:0]           m_axis_tuser,   // consumed[0], scroll_valid[1], coasting[2]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    wms_cmd_t    cmd;
    wms_status_t status;
    logic [24:0] out_amount;

    assign cfg_ready = 1'b1;

    wms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wms_dp #(
        .VELOCITY_FRAC_BITS (VELOCITY_FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_action  (s_axis_tuser),
        .in_delta   (s_axis_tdata[15:0]),
        .in_time    (s_axis_tdata[47:16]),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_amount (out_amount),
        .out_flags  (m_axis_tuser)
    );

    assign m_axis_tdata = {7'd0, out_amount};

endmodule

>>> rtl/core/wms_div.sv
// ----------------------------------------------------------------------------
// wms_div
// Restoring divider, one quotient bit per cycle. Shared between the notch
// remainder check and the velocity sample division.
// ----------------------------------------------------------------------------
module wms_div
    import wms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [STEP_W-1:0] steps,
    input  logic [31:0]       rem_init,
    input  logic [31:0]       quo_init,
    input  logic [31:0]       divisor,
    output logic              busy,
    output logic [31:0]       quotient,
    output logic [31:0]       remainder
);

    logic              busy_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       quo_reg;
    logic [31:0]       dvs_reg;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            quo_reg <= quo_init;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so 32 bits hold it
            rem_reg <= ge ? diff[31:0] : shifted[31:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/core/wms_dp.sv
// ----------------------------------------------------------------------------
// wms_dp
// Datapath: configuration, engine state, multipliers, divider and the
// output register.
// ----------------------------------------------------------------------------
module wms_dp
    import wms_pkg::*;
#(
    parameter int unsigned VELOCITY_FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  wms_cmd_t             cmd,
    output wms_status_t          status,
    input  logic [2:0]           in_action,
    input  logic [15:0]          in_delta,
    input  logic [31:0]          in_time,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [24:0]          out_amount,
    output logic [2:0]           out_flags
);

    localparam int unsigned F     = VELOCITY_FRAC_BITS;
    localparam int unsigned NUM_W = MV_K_W + F;

    logic [15:0] max_velocity_reg;
    logic [7:0]  scroll_gain_reg;
    logic [15:0] min_decel_reg;
    logic [9:0]  notch_size_reg;

    logic [2:0]  action_reg;
    logic [15:0] delta_reg;
    logic [31:0] time_reg;

    logic [31:0] velocity_reg;
    logic [31:0] last_time_reg;
    logic        last_time_valid_reg;
    logic        last_dir_up_reg;
    logic        running_reg;
    logic        run_dir_up_reg;
    logic        button_held_reg;

    logic [31:0]      elapsed_reg;
    logic [NUM_W-1:0] num_reg;
    logic [31:0]      sample_reg;
    logic [39:0]      prod_gain_reg;
    logic [63:0]      prod_sq_reg;

    logic        res_consumed_reg;
    logic        res_valid_reg;
    logic [24:0] res_amount_reg;

    logic        out_valid_reg;
    logic [24:0] out_amount_reg;
    logic [2:0]  out_flags_reg;

    logic              delta_neg;
    logic [15:0]       delta_mag;
    logic              dir_up;
    logic [MV_K_W-1:0] mv_k;
    logic              sample_sat;
    logic [32:0]       vel_sum;
    logic [39:0]       gain_shift;
    logic [23:0]       amt_mag;
    logic [24:0]       amount;
    logic [63:0]       sq_shift;
    logic [15:0]       min_eff;
    logic [31:0]       decel;
    logic              vel_zero;

    logic              div_start;
    logic [STEP_W-1:0] div_steps;
    logic [31:0]       div_rem_init;
    logic [31:0]       div_quo_init;
    logic [31:0]       div_divisor;
    logic              div_busy;
    logic [31:0]       div_quo;
    logic [31:0]       div_rem;

    // ---- wheel notch arithmetic
    assign delta_neg = delta_reg[15];
    assign delta_mag = delta_neg ? (16'd0 - delta_reg) : delta_reg;
    assign dir_up    = ~delta_neg;
    assign mv_k      = MV_K_W'(max_velocity_reg) * MS_TO_US;

    // quotient overflows 32 bits when the numerator's upper part reaches elapsed
    assign sample_sat = (elapsed_reg == 32'd0) ||
                        (32'(num_reg[NUM_W-1:32]) >= elapsed_reg);
    assign vel_sum    = {1'b0, velocity_reg} + {1'b0, sample_reg};

    // ---- tick arithmetic
    assign gain_shift = prod_gain_reg >> F;
    assign amt_mag    = (|gain_shift[39:24]) ? AMOUNT_MAX : gain_shift[23:0];
    assign amount     = run_dir_up_reg ? {1'b0, amt_mag} : (25'd0 - {1'b0, amt_mag});
    assign sq_shift   = prod_sq_reg >> (F + 4);
    assign min_eff    = (min_decel_reg == 16'd0) ? 16'd1 : min_decel_reg;
    assign decel      = (sq_shift[31:0] > 32'(min_eff)) ? sq_shift[31:0] : 32'(min_eff);
    assign vel_zero   = (|sq_shift[63:32]) || (decel >= velocity_reg);

    // ---- shared divider
    assign div_start    = cmd.mod_start | (cmd.div_load & ~sample_sat);
    assign div_steps    = cmd.mod_start ? MOD_STEPS : DIV_STEPS;
    assign div_rem_init = cmd.mod_start ? 32'd0 : 32'(num_reg[NUM_W-1:32]);
    assign div_quo_init = cmd.mod_start ? {delta_mag, 16'd0} : num_reg[31:0];
    assign div_divisor  = cmd.mod_start ? 32'(notch_size_reg) : elapsed_reg;

    wms_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .steps     (div_steps),
        .rem_init  (div_rem_init),
        .quo_init  (div_quo_init),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ---- status to the controller
    always_comb
    begin
        status            = '0;
        unique case (action_reg)
            ACT_WHEEL:   status.is_wheel   = 1'b1;
            ACT_TICK:    status.is_tick    = 1'b1;
            ACT_PRESS:   status.is_press   = 1'b1;
            ACT_RELEASE: status.is_release = 1'b1;
            default:     ;
        endcase
        status.mod_skip   = (delta_mag == 16'd0) || (notch_size_reg == 10'd0);
        status.rem_nz     = (div_rem != 32'd0);
        status.ltv        = last_time_valid_reg;
        status.running    = running_reg;
        status.stop_cond  = button_held_reg || (velocity_reg == 32'd0) ||
                            (last_dir_up_reg != run_dir_up_reg);
        status.sample_sat = sample_sat;
        status.div_busy   = div_busy;
        status.out_free   = ~out_valid_reg | out_ready;
    end

    // ---- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_velocity_reg <= MAX_VELOCITY_RST;
            scroll_gain_reg  <= SCROLL_GAIN_RST;
            min_decel_reg    <= MIN_DECEL_RST;
            notch_size_reg   <= NOTCH_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_VELOCITY: max_velocity_reg <= cfg_data;
                REG_SCROLL_GAIN:  scroll_gain_reg  <= cfg_data[7:0];
                REG_MIN_DECEL:    min_decel_reg    <= cfg_data;
                REG_NOTCH_SIZE:   notch_size_reg   <= cfg_data[9:0];
                default:          ;
            endcase
        end
    end

    // ---- engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_reg        <= '0;
            last_time_reg       <= '0;
            last_time_valid_reg <= 1'b0;
            last_dir_up_reg     <= 1'b0;
            running_reg         <= 1'b0;
            run_dir_up_reg      <= 1'b0;
            button_held_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.wheel_begin || cmd.btn_release)
            begin
                button_held_reg <= 1'b0;
            end
            if (cmd.btn_press)
            begin
                button_held_reg <= 1'b1;
            end
            if (cmd.vel_avg)
            begin
                velocity_reg <= (dir_up != last_dir_up_reg) ? 32'd0 : vel_sum[32:1];
            end
            if (cmd.notch_upd)
            begin
                if (!running_reg && velocity_reg != 32'd0)
                begin
                    running_reg    <= 1'b1;
                    run_dir_up_reg <= dir_up;
                end
                last_dir_up_reg     <= dir_up;
                last_time_reg       <= time_reg;
                last_time_valid_reg <= 1'b1;
            end
            if (cmd.tick_stop)
            begin
                running_reg         <= 1'b0;
                velocity_reg        <= '0;
                last_time_reg       <= '0;
                last_time_valid_reg <= 1'b0;
            end
            if (cmd.tick_upd)
            begin
                velocity_reg <= vel_zero ? 32'd0 : (velocity_reg - decel);
            end
        end
    end

    // ---- item and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            action_reg <= in_action;
            delta_reg  <= in_delta;
            time_reg   <= in_time;
        end
        if (cmd.elapsed_load)
        begin
            elapsed_reg <= time_reg - last_time_reg;
            num_reg     <= NUM_W'(mv_k) << F;
        end
        if (cmd.div_load)
        begin
            sample_reg <= 32'hFFFF_FFFF;
        end
        if (cmd.sample_take)
        begin
            sample_reg <= div_quo;
        end
        if (cmd.mul_load)
        begin
            prod_gain_reg <= 40'(velocity_reg) * 40'(scroll_gain_reg);
            prod_sq_reg   <= 64'(velocity_reg) * 64'(velocity_reg);
        end
    end

    // ---- result and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_consumed_reg <= 1'b0;
            res_valid_reg    <= 1'b0;
            res_amount_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.item_load)
            begin
                res_consumed_reg <= 1'b0;
                res_valid_reg    <= 1'b0;
                res_amount_reg   <= '0;
            end
            if (cmd.notch_upd)
            begin
                res_consumed_reg <= 1'b1;
            end
            if (cmd.tick_upd)
            begin
                res_valid_reg  <= 1'b1;
                res_amount_reg <= amount;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_amount_reg <= res_amount_reg;
            out_flags_reg  <= {running_reg, res_valid_reg, res_consumed_reg};
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_amount = out_amount_reg;
    assign out_flags  = out_flags_reg;

endmodule

>>> rtl/core/wms_ctrl.sv
// ----------------------------------------------------------------------------
// wms_ctrl
// Controller: sequences one item at a time through the datapath.
// ----------------------------------------------------------------------------
module wms_ctrl
    import wms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  wms_status_t status,
    output wms_cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_DECODE  = 10'b00_0000_0010,
        S_MOD     = 10'b00_0000_0100,
        S_ELAPSED = 10'b00_0000_1000,
        S_DIV_LD  = 10'b00_0001_0000,
        S_DIV     = 10'b00_0010_0000,
        S_AVG     = 10'b00_0100_0000,
        S_NOTCH   = 10'b00_1000_0000,
        S_TICK    = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                if (status.is_wheel)
                begin
                    cmd.wheel_begin = 1'b1;
                    if (!status.mod_skip)
                    begin
                        cmd.mod_start = 1'b1;
                        state_next    = S_MOD;
                    end
                end
                else if (status.is_tick)
                begin
                    if (status.running)
                    begin
                        if (status.stop_cond)
                        begin
                            cmd.tick_stop = 1'b1;
                        end
                        else
                        begin
                            cmd.mul_load = 1'b1;
                            state_next   = S_TICK;
                        end
                    end
                end
                else if (status.is_press)
                begin
                    cmd.btn_press = 1'b1;
                end
                else if (status.is_release)
                begin
                    cmd.btn_release = 1'b1;
                end
            end
            S_MOD:
            begin
                if (!status.div_busy)
                begin
                    if (status.rem_nz)
                    begin
                        state_next = S_DONE;
                    end
                    else if (status.ltv)
                    begin
                        cmd.elapsed_load = 1'b1;
                        state_next       = S_DIV_LD;
                    end
                    else
                    begin
                        state_next = S_NOTCH;
                    end
                end
            end
            S_ELAPSED:
            begin
                // not entered: elapsed time is captured on leaving S_MOD
                state_next = S_DIV_LD;
            end
            S_DIV_LD:
            begin
                cmd.div_load = 1'b1;
                state_next   = status.sample_sat ? S_AVG : S_DIV;
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.sample_take = 1'b1;
                    state_next      = S_AVG;
                end
            end
            S_AVG:
            begin
                cmd.vel_avg = 1'b1;
                state_next  = S_NOTCH;
            end
            S_NOTCH:
            begin
                cmd.notch_upd = 1'b1;
                state_next    = S_DONE;
            end
            S_TICK:
            begin
                cmd.tick_upd = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/wms_chk.sv
// ----------------------------------------------------------------------------
// wms_chk
// Port-level checks of the scroll engine, bound to the top level.
// ----------------------------------------------------------------------------
module wms_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one event in flight: no back-to-back input transfers
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // a result is never both a swallowed notch and a scroll
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("consumed and scroll_valid together");

    // no amount without scroll_valid
    a_amount: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[24:0] == 25'd0)
        else $error("amount without scroll_valid");

    // a scroll only happens while coasting continues, with zero tdata fill
    a_scroll_coast: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[2] && m_axis_tdata[31:25] == 7'd0)
        else $error("scroll while not coasting");

endmodule

bind wheel_momentum_scroll_engine_core wms_chk u_wms_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> sim/tb_wheel_momentum_scroll_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wheel_momentum_scroll_engine_core
// Self-checking bench for the wheel momentum scroll engine. A directed table
// covers reset behaviour, field extremes and the stop conditions. Random
// notch trains with ticks, button events and noise follow. These run under
// several register settings, with bursty input and a stalling output side.
// Non-fixed results are checked against an in-bench velocity and coasting model.
// ----------------------------------------------------------------------------
module tb_wheel_momentum_scroll_engine_core
    import wms_pkg::*;
();

    localparam int VEL_FRAC = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 120;
    localparam int DRAIN_CYCLES = 60;

    localparam logic [2:0] ACT_OTHER     = 3'd4;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic        consumed;
        logic        scroll_valid;
        logic [24:0] amount;
        logic        coasting;
    } scroll_result_t;

    typedef struct packed {
        logic [2:0]     act;
        logic [15:0]    delta;
        logic [31:0]    ev_time;
        logic           fixed;
        scroll_result_t want;
    } dir_row_t;

    localparam scroll_result_t RES_IDLE            = '{1'b0, 1'b0, 25'd0, 1'b0};
    localparam scroll_result_t RES_SWALLOWED       = '{1'b1, 1'b0, 25'd0, 1'b0};
    localparam scroll_result_t RES_SWALLOWED_COAST = '{1'b1, 1'b0, 25'd0, 1'b1};
    localparam scroll_result_t RES_COASTING        = '{1'b0, 1'b0, 25'd0, 1'b1};

    // rows with fixed = 0 are checked against the model only
    localparam int DIR_ROWS = 23;
    localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
        '{ACT_TICK,      16'h0000, 32'd0,        1'b1, RES_IDLE},
        '{ACT_OTHER,     16'h0000, 32'd0,        1'b1, RES_IDLE},
        '{ACT_UNUSED_HI, 16'h0000, 32'd0,        1'b1, RES_IDLE},
        '{ACT_WHEEL,     16'h0000, 32'd0,        1'b1, RES_IDLE},
        '{ACT_WHEEL,     16'h0001, 32'd0,        1'b1, RES_IDLE},
        '{ACT_WHEEL,     16'h0078, 32'd1000,     1'b1, RES_SWALLOWED},
        '{ACT_WHEEL,     16'h0078, 32'd1000,     1'b1, RES_SWALLOWED_COAST},
        '{ACT_TICK,      16'h0000, 32'd0,        1'b0, RES_IDLE},
        '{ACT_TICK,      16'h0000, 32'd0,        1'b0, RES_IDLE},
        '{ACT_WHEEL,     16'hFF88, 32'd2000,     1'b1, RES_SWALLOWED},
        '{ACT_WHEEL,     16'h8000, 32'd3000,     1'b1, RES_IDLE},
        '{ACT_WHEEL,     16'hFF10, 32'd12000,    1'b0, RES_IDLE},
        '{ACT_WHEEL,     16'h7FFF, 32'd0,        1'b1, RES_COASTING},
        '{ACT_TICK,      16'h0000, 32'd0,        1'b0, RES_IDLE},
        '{ACT_PRESS,     16'h0000, 32'd0,        1'b1, RES_COASTING},
        '{ACT_TICK,      16'h0000, 32'd0,        1'b1, RES_IDLE},
        '{ACT_RELEASE,   16'h0000, 32'd0,        1'b1, RES_IDLE},
        '{ACT_WHEEL,     16'h0078, 32'h00000000, 1'b1, RES_SWALLOWED},
        '{ACT_WHEEL,     16'h0078, 32'hFFFFFFFF, 1'b0, RES_IDLE},
        '{ACT_WHEEL,     16'h0078, 32'h00000010, 1'b0, RES_IDLE},
        '{ACT_WHEEL,     16'hFF88, 32'h00000020, 1'b0, RES_IDLE},
        '{ACT_TICK,      16'h0000, 32'd0,        1'b0, RES_IDLE},
        '{ACT_WHEEL,     16'hFFFF, 32'd5,        1'b1, RES_IDLE}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata;   // delta[15:0], event_time[47:16]
    logic [2:0]           s_axis_tuser;   // action[2:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;   // scroll_amount[24:0], zero fill
    logic [2:0]           m_axis_tuser;   // consumed[0], scroll_valid[1], coasting[2]
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    wheel_momentum_scroll_engine_core #(
        .VELOCITY_FRAC_BITS(VEL_FRAC)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // model copy of registers and engine state
    logic [15:0] mdl_max_vel;
    logic [7:0]  mdl_gain;
    logic [15:0] mdl_min_decel;
    logic [9:0]  mdl_notch;
    logic [31:0] mdl_vel;
    logic [31:0] mdl_last_time;
    logic        mdl_last_ok;
    logic        mdl_last_up;
    logic        mdl_running;
    logic        mdl_run_up;
    logic        mdl_btn_held;

    scroll_result_t pending_scroll [$];
    scroll_result_t got_res;
    scroll_result_t want_res;

    int          err_count;
    int          result_count;
    int          cycle_count;
    int          burst_left;
    int          phase_items;
    int          rx_hold_left;
    int          rx_mode;
    int          rx_mode_left;
    logic [31:0] cur_time;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH result %0d %s: got %0h, want %0h", result_count, what, got, want);
        err_count++;
    endtask

    task automatic predict_scroll(input logic [2:0] act, input logic [15:0] delta,
                                  input logic [31:0] ev_time, output scroll_result_t res);
        logic [16:0] mag;
        logic        up;
        logic [31:0] elapsed;
        logic [63:0] sample;
        logic [63:0] prod;
        logic [63:0] decel;
        logic [24:0] amt;
        res = RES_IDLE;
        case (act)
            ACT_WHEEL:
            begin
                up  = ~delta[15];
                mag = delta[15] ? (17'h10000 - {1'b0, delta}) : {1'b0, delta};
                mdl_btn_held = 1'b0;
                if (mag != 0 && mdl_notch != 0 && (mag % mdl_notch) == 0)
                begin
                    res.consumed = 1'b1;
                    if (mdl_last_ok)
                    begin
                        elapsed = ev_time - mdl_last_time;
                        if (elapsed == 0)
                            sample = 64'hFFFF_FFFF;
                        else
                        begin
                            sample = ((64'(mdl_max_vel) * 64'd1000) << VEL_FRAC)
                                     / 64'(elapsed);
                            if (sample > 64'hFFFF_FFFF)
                                sample = 64'hFFFF_FFFF;
                        end
                        if (up != mdl_last_up)
                            mdl_vel = '0;
                        else
                            mdl_vel = 32'((64'(mdl_vel) + sample) >> 1);
                    end
                    if (!mdl_running && mdl_vel != 0)
                    begin
                        mdl_running = 1'b1;
                        mdl_run_up  = up;
                    end
                    mdl_last_up   = up;
                    mdl_last_time = ev_time;
                    mdl_last_ok   = 1'b1;
                end
            end
            ACT_TICK:
            begin
                if (mdl_running)
                begin
                    if (mdl_btn_held || mdl_vel == 0 || mdl_last_up != mdl_run_up)
                    begin
                        mdl_running   = 1'b0;
                        mdl_vel       = '0;
                        mdl_last_time = '0;
                        mdl_last_ok   = 1'b0;
                    end
                    else
                    begin
                        prod = (64'(mdl_vel) * 64'(mdl_gain)) >> VEL_FRAC;
                        if (prod > 64'(AMOUNT_MAX))
                            prod = 64'(AMOUNT_MAX);
                        amt = {1'b0, prod[23:0]};
                        res.scroll_valid = 1'b1;
                        res.amount = mdl_run_up ? amt : (25'd0 - amt);
                        decel = (64'(mdl_vel) * 64'(mdl_vel)) >> (VEL_FRAC + 4);
                        if (decel < 64'(mdl_min_decel))
                            decel = 64'(mdl_min_decel);
                        if (decel == 0)
                            decel = 64'd1;
                        if (decel >= 64'(mdl_vel))
                            mdl_vel = '0;
                        else
                            mdl_vel = mdl_vel - decel[31:0];
                    end
                end
            end
            ACT_PRESS:   mdl_btn_held = 1'b1;
            ACT_RELEASE: mdl_btn_held = 1'b0;
            default:     ;
        endcase
        res.coasting = mdl_running;
    endtask

    // entered and left at a falling edge
    task automatic send_event(input logic [2:0] act, input logic [15:0] delta,
                              input logic [31:0] ev_time, input logic fixed,
                              input scroll_result_t want);
        int gap;
        scroll_result_t res;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_axis_tuser  = act;
        s_axis_tdata  = {ev_time, delta};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_scroll(act, delta, ev_time, res);
        pending_scroll.push_back(fixed ? want : res);
        phase_items++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MAX_VELOCITY: mdl_max_vel   = value;
            REG_SCROLL_GAIN:  mdl_gain      = value[7:0];
            REG_MIN_DECEL:    mdl_min_decel = value;
            REG_NOTCH_SIZE:   mdl_notch     = value[9:0];
            default:          ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] max_vel, input logic [7:0] gain,
                              input logic [15:0] min_decel, input logic [9:0] notch);
        write_reg(REG_MAX_VELOCITY, max_vel);
        write_reg(REG_SCROLL_GAIN, {8'd0, gain});
        write_reg(REG_MIN_DECEL, min_decel);
        write_reg(REG_NOTCH_SIZE, {6'd0, notch});
        cfg_valid = 1'b0;
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (pending_scroll.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // elapsed time between notches, spread over many decades
    function automatic logic [31:0] pick_gap();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom;
            default: return $urandom_range(1, 1 << $urandom_range(6, 22));
        endcase
    endfunction

    function automatic logic [15:0] notch_delta(input logic up);
        int kmax;
        int k;
        logic [15:0] mag;
        kmax = 32767 / int'(mdl_notch);
        if ($urandom_range(0, 9) == 0)
            k = kmax;
        else
            k = $urandom_range(1, (kmax < 4) ? kmax : 4);
        mag = 16'(k * int'(mdl_notch));
        return up ? mag : (16'd0 - mag);
    endfunction

    // a notch train that gets the engine coasting, then ticks with disturbances
    task automatic run_coast_train();
        logic up;
        int   n;
        int   ticks;
        int   i;
        up = 1'($urandom_range(0, 1));
        n  = $urandom_range(2, 4);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                up = ~up;
            cur_time = cur_time + pick_gap();
            send_event(ACT_WHEEL, notch_delta(up), cur_time, 1'b0, RES_IDLE);
        end
        ticks = $urandom_range(1, 25);
        for (i = 0; i < ticks; i++)
        begin
            case ($urandom_range(0, 19))
                0: send_event(ACT_PRESS, 16'($urandom), $urandom, 1'b0, RES_IDLE);
                1: send_event(ACT_RELEASE, 16'($urandom), $urandom, 1'b0, RES_IDLE);
                2: send_event(ACT_OTHER, 16'($urandom), $urandom, 1'b0, RES_IDLE);
                3:
                begin
                    cur_time = cur_time + pick_gap();
                    send_event(ACT_WHEEL, notch_delta(up), cur_time, 1'b0, RES_IDLE);
                end
                4: send_event(ACT_WHEEL, notch_delta(up) + 16'd1, cur_time, 1'b0, RES_IDLE);
                default: send_event(ACT_TICK, 16'($urandom), $urandom, 1'b0, RES_IDLE);
            endcase
        end
    endtask

    task automatic run_noise();
        int n;
        int i;
        logic [15:0] delta;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
        begin
            delta = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                : notch_delta(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1) == 0)
                cur_time = $urandom;
            else
                cur_time = cur_time + pick_gap();
            send_event(3'($urandom_range(0, 7)), delta, cur_time, 1'b0, RES_IDLE);
        end
    endtask

    // output side: random stall patterns, plus one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        rx_mode = 0;
        rx_mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                rx_hold_left--;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode = $urandom_range(0, 2);
                    rx_mode_left = $urandom_range(20, 200);
                end
                else
                    rx_mode_left--;
                case (rx_mode)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = 1'($urandom_range(0, 1));
                    default: m_axis_tready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res.consumed     = m_axis_tuser[0];
            got_res.scroll_valid = m_axis_tuser[1];
            got_res.coasting     = m_axis_tuser[2];
            got_res.amount       = m_axis_tdata[24:0];
            if (pending_scroll.size() == 0)
                report_mismatch("unexpected transfer",
                                32'({m_axis_tuser, m_axis_tdata[24:0]}), 32'd0);
            else
            begin
                want_res = pending_scroll.pop_front();
                if (got_res.consumed != want_res.consumed)
                    report_mismatch("consumed", 32'(got_res.consumed),
                                    32'(want_res.consumed));
                if (got_res.scroll_valid != want_res.scroll_valid)
                    report_mismatch("scroll_valid", 32'(got_res.scroll_valid),
                                    32'(want_res.scroll_valid));
                if (got_res.amount != want_res.amount)
                    report_mismatch("scroll_amount", 32'(got_res.amount),
                                    32'(want_res.amount));
                if (got_res.coasting != want_res.coasting)
                    report_mismatch("coasting", 32'(got_res.coasting),
                                    32'(want_res.coasting));
                if (m_axis_tdata[31:25] != 0)
                    report_mismatch("tdata fill", 32'(m_axis_tdata[31:25]), 32'd0);
            end
            result_count++;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TIMEOUT after %0d cycles, %0d results pending",
                 cycle_count, pending_scroll.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rx_hold_left  = 0;
        err_count     = 0;
        result_count  = 0;
        burst_left    = 0;
        phase_items   = 0;
        cur_time      = '0;

        mdl_max_vel   = MAX_VELOCITY_RST;
        mdl_gain      = SCROLL_GAIN_RST;
        mdl_min_decel = MIN_DECEL_RST;
        mdl_notch     = NOTCH_SIZE_RST;
        mdl_vel       = '0;
        mdl_last_time = '0;
        mdl_last_ok   = 1'b0;
        mdl_last_up   = 1'b0;
        mdl_running   = 1'b0;
        mdl_run_up    = 1'b0;
        mdl_btn_held  = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_event(DIR_TAB[i].act, DIR_TAB[i].delta, DIR_TAB[i].ev_time,
                       DIR_TAB[i].fixed, DIR_TAB[i].want);

        for (int p = 0; p < 5; p++)
        begin
            drain_results();
            case (p)
                1: set_config(16'd65535, 8'd255, 16'd65535, 10'd1023);
                2: set_config(16'd1, 8'd1, 16'd1, 10'd1);
                3: set_config(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)),
                              16'($urandom_range(1, 65535)), 10'($urandom_range(1, 1023)));
                4: set_config(16'($urandom_range(1, 4000)), 8'($urandom_range(1, 255)),
                              16'($urandom_range(1, 2000)), 10'($urandom_range(1, 200)));
                default: ;
            endcase
            // long output hold-off while input keeps coming, so the block backs up
            if (p == 1)
                rx_hold_left = 400;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 3) == 0)
                    run_noise();
                else
                    run_coast_train();
                // sender pause until everything has come back
                if (p == 3 && phase_items >= PHASE_ITEMS / 2 && rx_hold_left == 0
                    && pending_scroll.size() != 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (100) @(negedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/wms_pkg.sv
rtl/core/wms_div.sv
rtl/core/wms_dp.sv
rtl/core/wms_ctrl.sv
rtl/core/wheel_momentum_scroll_engine_core.sv
rtl/core/wms_chk.sv
sim/tb_wheel_momentum_scroll_engine_core.sv
